// ----- design/pabg_pkg.sv -----
// shared types, constants and delay tables of the passphrase attempt backoff gate
package pabg_pkg;

  // command codes
  localparam logic CMD_BOOT    = 1'b0;
  localparam logic CMD_ATTEMPT = 1'b1;

  // status codes
  localparam logic [1:0] ST_BOOT    = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_WRONG   = 2'd3;

  localparam logic [9:0]  DELAY_BASE_S  = 10'd5;
  localparam logic [9:0]  DELAY_CAP_S   = 10'd900;
  localparam logic [19:0] DELAY_BASE_MS = 20'd5000;
  localparam logic [19:0] DELAY_CAP_MS  = 20'd900000;
  localparam logic [7:0]  NEED_CAP      = 8'd180;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;
  // first count at which the doubled delay hits the cap
  localparam logic [7:0]  COUNT_AT_CAP  = 8'd9;
  // ceil(2^30 / 1000), exact floor(x / 1000) for x below 2^20
  localparam logic [20:0] RECIP_1000    = 21'd1073742;
  localparam int          RECIP_SHIFT   = 30;

  typedef struct packed {
    logic [7:0]  attempt_count;
    logic [7:0]  boots_since_failure;
    logic [31:0] last_failure_epoch;
    logic [47:0] last_failure_uptime;
  } pabg_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] remaining_s;
    logic [7:0] attempts_now;
  } pabg_res_t;

  // backoff delay in seconds for a failed-attempt count
  function automatic logic [9:0] delay_of(input logic [7:0] n);
    logic [7:0] nm1;
    nm1 = n - 8'd1;
    if (n == 8'd0) begin
      delay_of = 10'd0;
    end else if (n >= COUNT_AT_CAP) begin
      delay_of = DELAY_CAP_S;
    end else begin
      delay_of = DELAY_BASE_S << nm1[2:0];
    end
  endfunction

  // same delay in milliseconds
  function automatic logic [19:0] delay_ms_of(input logic [7:0] n);
    logic [7:0] nm1;
    nm1 = n - 8'd1;
    if (n == 8'd0) begin
      delay_ms_of = 20'd0;
    end else if (n >= COUNT_AT_CAP) begin
      delay_ms_of = DELAY_CAP_MS;
    end else begin
      delay_ms_of = DELAY_BASE_MS << nm1[2:0];
    end
  endfunction

  // boots needed to wear off the delay, at least one
  function automatic logic [7:0] need_of(input logic [7:0] n);
    logic [7:0] nm1;
    nm1 = n - 8'd1;
    if (n == 8'd0) begin
      need_of = 8'd1;
    end else if (n >= COUNT_AT_CAP) begin
      need_of = NEED_CAP;
    end else begin
      need_of = 8'd1 << nm1[2:0];
    end
  endfunction

endpackage

// ----- design/pabg_wait.sv -----
// remaining backoff wait: largest of the uptime, wall-clock and boot-count waits
module pabg_wait (
  input  pabg_pkg::pabg_state_t st,
  input  logic [31:0]           wall_s,
  input  logic [47:0]           uptime_ms,
  output logic [9:0]            wait_s
);
  import pabg_pkg::*;

  logic [9:0]  delay;
  logic [19:0] delay_ms;
  logic [7:0]  need;
  logic [47:0] up_diff;
  logic [40:0] prod;
  logic [9:0]  el_up;
  logic [31:0] ep_diff;
  logic [7:0]  boot_gap;
  logic [9:0]  rem_up;
  logic [9:0]  rem_ep;
  logic [9:0]  rem_bt;
  logic [9:0]  rem_max;

  always_comb begin
    delay    = delay_of(st.attempt_count);
    delay_ms = delay_ms_of(st.attempt_count);
    need     = need_of(st.attempt_count);

    // uptime wait, only meaningful when the diff is under the delay
    up_diff = uptime_ms - st.last_failure_uptime;
    prod    = 41'(up_diff[19:0]) * 41'(RECIP_1000);
    el_up   = prod[RECIP_SHIFT +: 10];
    if (st.last_failure_uptime == 48'd0) begin
      rem_up = 10'd0;
    end else if (uptime_ms < st.last_failure_uptime) begin
      rem_up = delay;
    end else if (up_diff < {28'd0, delay_ms}) begin
      rem_up = delay - el_up;
    end else begin
      rem_up = 10'd0;
    end

    // wall-clock wait, skipped without a clock or with the clock behind
    ep_diff = wall_s - st.last_failure_epoch;
    if (wall_s != 32'd0 && st.last_failure_epoch != 32'd0 &&
        wall_s >= st.last_failure_epoch && ep_diff < {22'd0, delay}) begin
      rem_ep = delay - ep_diff[9:0];
    end else begin
      rem_ep = 10'd0;
    end

    // boot-count wait, 5 s for each missing boot
    boot_gap = need - st.boots_since_failure;
    if (st.boots_since_failure < need) begin
      rem_bt = {2'd0, boot_gap} * DELAY_BASE_S;
    end else begin
      rem_bt = 10'd0;
    end

    rem_max = (rem_up > rem_ep) ? rem_up : rem_ep;
    if (rem_bt > rem_max) begin
      rem_max = rem_bt;
    end

    wait_s = (st.attempt_count == 8'd0) ? 10'd0 : rem_max;
  end

endmodule

// ----- design/pabg_state.sv -----
// backoff state registers and the per-beat update and result logic
module pabg_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                cmd,
  input  logic                pass_ok,
  input  logic [31:0]         wall_s,
  input  logic [47:0]         uptime_ms,
  output pabg_pkg::pabg_res_t res
);
  import pabg_pkg::*;

  pabg_state_t st_r;
  pabg_state_t st_nxt;
  logic [9:0]  wait_s;
  logic [7:0]  cnt_inc;

  pabg_wait u_wait (
    .st        (st_r),
    .wall_s    (wall_s),
    .uptime_ms (uptime_ms),
    .wait_s    (wait_s)
  );

  always_comb begin
    st_nxt  = st_r;
    cnt_inc = (st_r.attempt_count == COUNT_MAX) ? COUNT_MAX : st_r.attempt_count + 8'd1;
    res.status       = ST_BOOT;
    res.remaining_s  = 10'd0;
    res.attempts_now = st_r.attempt_count;
    if (cmd == CMD_BOOT) begin
      st_nxt.last_failure_uptime = 48'd0;
      if (st_r.attempt_count != 8'd0 && st_r.attempt_count != COUNT_MAX &&
          st_r.boots_since_failure != COUNT_MAX) begin
        st_nxt.boots_since_failure = st_r.boots_since_failure + 8'd1;
      end
    end else if (wait_s != 10'd0) begin
      res.status      = ST_BLOCKED;
      res.remaining_s = wait_s;
    end else if (pass_ok) begin
      st_nxt           = '0;
      res.status       = ST_GRANTED;
      res.attempts_now = 8'd0;
    end else begin
      st_nxt.attempt_count       = cnt_inc;
      st_nxt.boots_since_failure = 8'd0;
      st_nxt.last_failure_epoch  = wall_s;
      st_nxt.last_failure_uptime = (uptime_ms != 48'd0) ? uptime_ms : 48'd1;
      res.status                 = ST_WRONG;
      res.remaining_s            = delay_of(cnt_inc);
      res.attempts_now           = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ----- design/passphrase_attempt_backoff_gate_top.sv -----
// top level of the passphrase attempt backoff gate: input stage, state update, result stage
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_ready  | cmd, pass_ok, wall_s, uptime_ms
//   out_    | out       | out_valid/out_ready| status, remaining_s, attempts_now
//
// one beat per cycle sustained while out_ready stays high; the input register feeds the
// result register (state update and result register in the same cycle)
// synchronous active-low reset clears both stage valids and the backoff state
// a stalled result holds the result register; the input register still takes a beat
// when empty, and in_ready follows out_ready once both stages are full
module passphrase_attempt_backoff_gate_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic        in_pass_ok,
  input  logic [31:0] in_wall_s,
  input  logic [47:0] in_uptime_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_remaining_s,
  output logic [7:0]  out_attempts_now
);
  import pabg_pkg::*;

  // input stage
  logic        in_v_r;
  logic        cmd_r;
  logic        pass_ok_r;
  logic [31:0] wall_s_r;
  logic [47:0] uptime_ms_r;

  // result stage
  logic        out_v_r;
  pabg_res_t   res_r;
  pabg_res_t   res;

  // a beat leaves the input stage when the result stage is free or draining
  logic        adv;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  pabg_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .cmd       (cmd_r),
    .pass_ok   (pass_ok_r),
    .wall_s    (wall_s_r),
    .uptime_ms (uptime_ms_r),
    .res       (res)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r       <= in_cmd;
      pass_ok_r   <= in_pass_ok;
      wall_s_r    <= in_wall_s;
      uptime_ms_r <= in_uptime_ms;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = res_r.status;
  assign out_remaining_s  = res_r.remaining_s;
  assign out_attempts_now = res_r.attempts_now;

endmodule

// ----- tb/tb_passphrase_attempt_backoff_gate_top.sv -----
// self-checking testbench for the passphrase attempt backoff gate top level
`timescale 1ns / 100ps

module tb_passphrase_attempt_backoff_gate_top;
  import pabg_pkg::*;

  // arithmetic of the backoff rules that the package does not provide
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned NEED_ROUND   = 4;
  localparam int          MAX_REPORTED = 10;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic        in_cmd           = CMD_BOOT;
  logic        in_pass_ok       = 1'b0;
  logic [31:0] in_wall_s        = '0;
  logic [47:0] in_uptime_ms     = '0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_remaining_s;
  logic [7:0]  out_attempts_now;

  // backoff state as the gate should hold it after every accepted beat
  logic [7:0]  gate_attempts;
  logic [7:0]  gate_boots;
  logic [31:0] gate_fail_epoch;
  logic [47:0] gate_fail_uptime;

  // verdicts still owed by the block, oldest first
  pabg_res_t   pending_results[$];
  int          mismatch_count = 0;

  // idling switches for the sender and the receiver
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  passphrase_attempt_backoff_gate_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pass_ok       (in_pass_ok),
    .in_wall_s        (in_wall_s),
    .in_uptime_ms     (in_uptime_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_remaining_s  (out_remaining_s),
    .out_attempts_now (out_attempts_now)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // delay in seconds for n failed attempts: 5 s doubling, capped
  function automatic logic [9:0] delay_for_count(input logic [7:0] n);
    int unsigned d;
    d = 32'(DELAY_BASE_S);
    if (n == 8'd0) return 10'd0;
    for (int i = 1; i < n; i++) begin
      d = d * 2;
      if (d >= DELAY_CAP_S) return DELAY_CAP_S;
    end
    return d[9:0];
  endfunction

  // boots that wear off the delay, each one worth 5 s
  function automatic int unsigned boot_quota(input logic [7:0] n);
    int unsigned need;
    need = (delay_for_count(n) + NEED_ROUND) / DELAY_BASE_S;
    if (need > COUNT_MAX) need = COUNT_MAX;
    if (need == 0) need = 1;
    return need;
  endfunction

  // largest of the uptime, wall-clock and boot-count waits
  function automatic logic [9:0] wait_remaining(input logic [31:0] now,
                                                input logic [47:0] up);
    logic [9:0]  delay;
    logic [47:0] secs;
    logic [31:0] el;
    int unsigned need;
    int unsigned rem;
    delay = delay_for_count(gate_attempts);
    rem   = 0;
    // uptime wait, elapsed clamps at zero below the mark and saturates at 32 bits
    if (gate_fail_uptime != '0) begin
      secs = (up >= gate_fail_uptime) ? (up - gate_fail_uptime) / MS_PER_S : 48'd0;
      el   = (secs > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : secs[31:0];
      if (el < delay && delay - el > rem) rem = delay - el;
    end
    // wall-clock wait only with a valid clock that is not behind the mark
    if (now != '0 && gate_fail_epoch != '0 && now >= gate_fail_epoch) begin
      el = now - gate_fail_epoch;
      if (el < delay && delay - el > rem) rem = delay - el;
    end
    need = boot_quota(gate_attempts);
    if (gate_boots < need && (need - gate_boots) * DELAY_BASE_S > rem)
      rem = (need - gate_boots) * DELAY_BASE_S;
    return rem[9:0];
  endfunction

  // applies one event to the backoff state and returns the verdict it yields
  function automatic pabg_res_t predict_gate(input logic cmd, input logic ok,
                                             input logic [31:0] now,
                                             input logic [47:0] up);
    pabg_res_t r;
    r.remaining_s = '0;
    if (cmd == CMD_BOOT) begin
      gate_fail_uptime = '0;
      // boots count only while a backoff is running and below saturation
      if (gate_attempts != 8'd0 && gate_attempts != COUNT_MAX && gate_boots != COUNT_MAX)
        gate_boots = gate_boots + 8'd1;
      r.status = ST_BOOT;
    end else begin
      if (gate_attempts != 8'd0) r.remaining_s = wait_remaining(now, up);
      if (r.remaining_s != '0) begin
        r.status = ST_BLOCKED;
      end else begin
        // reserve the attempt as a failure before the verdict lands
        if (gate_attempts != COUNT_MAX) gate_attempts = gate_attempts + 8'd1;
        gate_boots      = '0;
        gate_fail_epoch = now;
        if (ok) begin
          gate_attempts    = '0;
          gate_fail_epoch  = '0;
          gate_fail_uptime = '0;
          r.status         = ST_GRANTED;
        end else begin
          gate_fail_uptime = (up != '0) ? up : 48'd1;
          r.remaining_s    = delay_for_count(gate_attempts);
          r.status         = ST_WRONG;
        end
      end
    end
    r.attempts_now = gate_attempts;
    return r;
  endfunction

  function automatic logic [47:0] rand_uptime();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return 48'd0;
      1: return 48'($urandom_range(0, 20000));
      default: return raw[47:0];
    endcase
  endfunction

  // sends one beat after a random gap, then books its verdict
  task automatic send_event(input logic cmd, input logic ok, input logic [31:0] now,
                            input logic [47:0] up);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_pass_ok   <= ok;
    in_wall_s    <= now;
    in_uptime_ms <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_gate(cmd, ok, now, up));
  endtask

  // sender holds off until every booked verdict is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // granted with nothing on record, first failure, attempts below the mark
  task automatic test_first_attempts();
    send_event(CMD_ATTEMPT, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    // zero uptime is recorded as a mark of one
    send_event(CMD_ATTEMPT, 1'b0, 32'd1000, 48'd0);
    // uptime below the mark, and a pass verdict on a blocked attempt
    send_event(CMD_ATTEMPT, 1'b1, 32'd0, 48'd0);
    // elapsed uptime far beyond 32 bits of seconds
    send_event(CMD_ATTEMPT, 1'b0, 32'd0, 48'hFFFF_FFFF_FFFF);
  endtask

  // wall-clock wait, clock behind, no clock, failure recorded without a clock
  task automatic test_epoch_rules();
    // a boot ignores its other fields
    send_event(CMD_BOOT, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_event(CMD_ATTEMPT, 1'b0, 32'd1002, 48'd5);
    send_event(CMD_ATTEMPT, 1'b1, 32'd1004, 48'd5);
    send_event(CMD_ATTEMPT, 1'b0, 32'd999, 48'hFFFF_FFFF_FFFF);
    repeat (2) send_event(CMD_BOOT, 1'b0, 32'd0, 48'd0);
    send_event(CMD_ATTEMPT, 1'b0, 32'd0, 48'd77);
    repeat (4) send_event(CMD_BOOT, 1'b1, 32'd0, 48'd0);
    send_event(CMD_ATTEMPT, 1'b1, 32'h8000_0000, 48'd1);
    // boot with nothing on record is not counted
    send_event(CMD_BOOT, 1'b0, 32'd5, 48'd5);
  endtask

  // boot count saturates instead of wrapping back into a wait
  task automatic test_boot_saturation();
    tx_idle_en = 1'b0;
    send_event(CMD_ATTEMPT, 1'b0, 32'd0, 48'd10);
    repeat (300) send_event(CMD_BOOT, 1'b0, 32'd0, 48'd0);
    tx_idle_en = 1'b1;
    send_event(CMD_ATTEMPT, 1'b0, 32'd0, 48'd10);
    repeat (2) send_event(CMD_BOOT, 1'b0, 32'd0, 48'd0);
    send_event(CMD_ATTEMPT, 1'b1, 32'd0, 48'd10);
  endtask

  // mostly well-formed sessions: fail, boot until the count wears off, retry
  task automatic test_random_sessions(input int n_items);
    logic [9:0]  delay;
    logic [31:0] now;
    logic        ok;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (k % 300 == 299) wait_drained();
      delay = delay_for_count(gate_attempts);
      if ($urandom_range(0, 9) == 0) begin
        // noise beat
        send_event(1'($urandom), 1'($urandom), $urandom, rand_uptime());
      end else if (gate_attempts != 8'd0 && gate_boots < boot_quota(gate_attempts) &&
                   $urandom_range(0, 9) != 0) begin
        send_event(CMD_BOOT, 1'($urandom), $urandom, rand_uptime());
      end else begin
        // push toward a pass once the count gets expensive
        ok = (gate_attempts >= 8'd6) ? ($urandom_range(0, 2) != 0)
                                     : ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0:       now = '0;
          1, 2:    now = $urandom;
          3, 4:    now = gate_fail_epoch + $urandom_range(0, delay);
          default: now = gate_fail_epoch + delay + $urandom_range(0, 5000);
        endcase
        send_event(CMD_ATTEMPT, ok, now, rand_uptime());
      end
    end
  endtask

  // climbs the count through the doubling delays into the capped one
  task automatic test_count_climb();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (gate_attempts < COUNT_AT_CAP) begin
      if (gate_attempts != 8'd0 && gate_boots < boot_quota(gate_attempts))
        send_event(CMD_BOOT, 1'b0, 32'd0, 48'd0);
      else
        send_event(CMD_ATTEMPT, 1'b0, 32'd0, rand_uptime());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (4) begin
      send_event(CMD_BOOT, 1'($urandom), $urandom, rand_uptime());
      send_event(CMD_ATTEMPT, 1'($urandom), $urandom, rand_uptime());
    end
  endtask

  // receiver: random stall before each beat, then ready until one is taken
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // every result beat against the oldest booked verdict
  always @(posedge clk) begin : result_check
    pabg_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("unexpected result beat: status %0d remaining %0d attempts %0d",
                   out_status, out_remaining_s, out_attempts_now);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_remaining_s !== want.remaining_s ||
            out_attempts_now !== want.attempts_now) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("mismatch: expected status %0d remaining %0d attempts %0d, %s %0d %0d %0d",
                     want.status, want.remaining_s, want.attempts_now,
                     "got", out_status, out_remaining_s, out_attempts_now);
        end
      end
    end
  end

  initial begin : test_sequence
    gate_attempts    = '0;
    gate_boots       = '0;
    gate_fail_epoch  = '0;
    gate_fail_uptime = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_attempts();
    test_epoch_rules();
    test_boot_saturation();
    test_random_sessions(700);
    test_count_climb();
    wait_drained();
    // time for any stray beat to show up
    repeat (8) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit, well beyond the slowest correct run
  initial begin : run_limit
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pabg_pkg.sv
design/pabg_wait.sv
design/pabg_state.sv
design/passphrase_attempt_backoff_gate_top.sv
tb/tb_passphrase_attempt_backoff_gate_top.sv
